[src/flba_pkg.sv]
package flba_pkg;

    localparam int FIRST_BLOCK = 2;
    localparam int NEED_W      = 13;
    localparam int CMP_W       = 17;
    localparam int IN_W        = 40;
    localparam int OUT_W       = 40;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_QUERY   = 2'd2,
        OP_REBUILD = 2'd3
    } opcode_t;

    typedef enum logic [0:0] {
        REG_FIT_MODE    = 1'b0,
        REG_ARENA_BYTES = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DEC,
        S_RD,
        S_EV,
        S_POST,
        S_SPLIT_HI,
        S_SPLIT_LO,
        S_MARK,
        S_MRD,
        S_MEV,
        S_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic rebuild;
        logic walk_start;
        logic step;
        logic split_hi;
        logic split_lo;
        logic mark;
        logic merge_step;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    req_zero;
        logic    addr_ok;
        logic    walk_done;
        logic    merge_done;
        logic    found;
        logic    hit;
        logic    hit_free;
        logic    out_busy;
    } sts_t;

endpackage

[src/flba_ctrl.sv]
module flba_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  flba_pkg::sts_t  sts,
    output flba_pkg::cmd_t  cmd
);
    import flba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == S_IDLE);
        case (state_reg)
            S_INIT:
            begin
                cmd.rebuild = 1'b1;
                state_next  = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (sts.op)
                    OP_REBUILD:
                    begin
                        cmd.rebuild = 1'b1;
                        state_next  = S_RESP;
                    end
                    OP_ALLOC:
                    begin
                        if (sts.req_zero)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_RD;
                        end
                    end
                    default:
                    begin
                        if (sts.addr_ok)
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_RD;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                endcase
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                cmd.step   = 1'b1;
                state_next = sts.walk_done ? S_POST : S_RD;
            end
            S_POST:
            begin
                case (sts.op)
                    OP_ALLOC:
                    begin
                        state_next = sts.found ? S_SPLIT_HI : S_RESP;
                    end
                    OP_FREE:
                    begin
                        state_next = (sts.hit && !sts.hit_free) ? S_MARK : S_RESP;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SPLIT_HI:
            begin
                cmd.split_hi = 1'b1;
                state_next   = S_SPLIT_LO;
            end
            S_SPLIT_LO:
            begin
                cmd.split_lo = 1'b1;
                state_next   = S_RESP;
            end
            S_MARK:
            begin
                cmd.mark       = 1'b1;
                cmd.walk_start = 1'b1;
                state_next     = S_MRD;
            end
            S_MRD:
            begin
                state_next = S_MEV;
            end
            S_MEV:
            begin
                cmd.merge_step = 1'b1;
                state_next     = sts.merge_done ? S_RESP : S_MRD;
            end
            S_RESP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.rebuild, cmd.split_hi, cmd.split_lo, cmd.mark, cmd.merge_step}))
        else $error("two store writes requested at once");
    a_split_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.split_hi |=> cmd.split_lo)
        else $error("split did not write its low part");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_DEC))
        else $error("accepted transaction not decoded");
`endif

endmodule

[src/flba_dp.sv]
module flba_dp #(
    parameter int ARENA_GRANULES = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [flba_pkg::IN_W-1:0]      s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [flba_pkg::OUT_W-1:0]     m_tdata,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [16:0]                    cfg_data,
    input  flba_pkg::cmd_t                 cmd,
    output flba_pkg::sts_t                 sts
);
    import flba_pkg::*;

    localparam int AW = (ARENA_GRANULES > 1) ? $clog2(ARENA_GRANULES) : 1;
    localparam int GW = AW + 1;
    localparam int SW = AW;
    localparam int RESET_GRAN = (ARENA_GRANULES < 4096) ? ARENA_GRANULES : 4096;

    logic [SW:0] mem [ARENA_GRANULES];
    logic [SW:0] rd_reg;

    logic             fit_mode_reg;
    logic [16:0]      arena_bytes_reg;
    logic [GW-1:0]    gran_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] res_reg;
    logic [OUT_W-1:0] res_next;

    opcode_t          op_reg;
    logic             req_zero_reg;
    logic             addr_ok_reg;
    logic [NEED_W-1:0] need_reg;
    logic [11:0]      start_reg;
    logic [GW-1:0]    g_reg;
    logic [AW-1:0]    best_reg;
    logic [SW-1:0]    best_size_reg;
    logic             found_reg;
    logic             hit_reg;
    logic             hit_free_reg;
    logic [SW-1:0]    hit_size_reg;
    logic [AW-1:0]    run_reg;
    logic [SW-1:0]    acc_reg;
    logic             in_run_reg;
    logic             multi_reg;

    logic [1:0]       in_op;
    logic [15:0]      in_req;
    logic [15:0]      in_off;
    logic [16:0]      t_req;
    logic [16:0]      need_sum;
    logic [CMP_W-1:0] gran_raw;
    logic [GW-1:0]    gran_new;

    logic             blk_free;
    logic [SW-1:0]    blk_size;
    logic [GW-1:0]    g_add;
    logic             end_c;
    logic             fits;
    logic             g_eq;
    logic             g_gt;
    logic             stop_c;
    logic [SW-1:0]    acc_sum;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [SW:0]      wdata;
    logic [GW-1:0]    split_addr;

    assign in_op  = s_tdata[1:0];
    assign in_req = s_tdata[17:2];
    assign in_off = s_tdata[33:18];
    assign t_req    = (in_req < 16'd16) ? 17'd16 : {1'b0, in_req};
    assign need_sum = t_req + 17'd23;

    always_comb
    begin
        gran_raw = {4'd0, arena_bytes_reg[16:4]};
        if (gran_raw < CMP_W'(4))
        begin
            gran_raw = CMP_W'(4);
        end
        if (gran_raw > CMP_W'(ARENA_GRANULES))
        begin
            gran_raw = CMP_W'(ARENA_GRANULES);
        end
    end
    assign gran_new = GW'(gran_raw);

    assign blk_free = rd_reg[SW];
    assign blk_size = rd_reg[SW-1:0];
    assign g_add    = g_reg + GW'(blk_size);
    assign end_c    = (g_add >= gran_reg);
    assign fits     = blk_free && (CMP_W'(blk_size) >= CMP_W'(need_reg));
    assign g_eq     = (CMP_W'(g_reg) == CMP_W'(start_reg));
    assign g_gt     = (CMP_W'(g_reg) > CMP_W'(start_reg));
    assign stop_c   = (op_reg == OP_ALLOC) ? (fits && !fit_mode_reg) : (g_eq || g_gt);
    assign acc_sum  = acc_reg + blk_size;
    assign split_addr = GW'(best_reg) + GW'(need_reg);

    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (cmd.rebuild)
        begin
            we    = 1'b1;
            waddr = AW'(FIRST_BLOCK);
            wdata = {1'b1, SW'(gran_new - GW'(FIRST_BLOCK))};
        end
        else if (cmd.split_hi)
        begin
            we    = (CMP_W'(best_size_reg) > CMP_W'(need_reg));
            waddr = split_addr[AW-1:0];
            wdata = {1'b1, SW'(best_size_reg - SW'(need_reg))};
        end
        else if (cmd.split_lo)
        begin
            we    = 1'b1;
            waddr = best_reg;
            wdata = {1'b0, SW'(need_reg)};
        end
        else if (cmd.mark)
        begin
            we    = 1'b1;
            waddr = start_reg[AW-1:0];
            wdata = {1'b1, hit_size_reg};
        end
        else if (cmd.merge_step)
        begin
            waddr = run_reg;
            if (blk_free)
            begin
                we    = end_c && in_run_reg;
                wdata = {1'b1, acc_sum};
            end
            else
            begin
                we    = in_run_reg && multi_reg;
                wdata = {1'b1, acc_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[g_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg    <= 1'b1;
            arena_bytes_reg <= 17'd65536;
            gran_reg        <= GW'(RESET_GRAN);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_FIT_MODE)
            begin
                fit_mode_reg <= cfg_data[0];
            end
            if (cfg_we && cfg_index == REG_ARENA_BYTES)
            begin
                arena_bytes_reg <= cfg_data;
            end
            if (cmd.rebuild)
            begin
                fit_mode_reg <= 1'b1;
                gran_reg     <= gran_new;
            end
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result fields: status, payload offset and usable bytes.
    always_comb
    begin
        res_next = '0;
        if (op_reg == OP_ALLOC)
        begin
            res_next[0] = !found_reg;
            if (found_reg)
            begin
                res_next[16:1]  = 16'(({4'd0, best_reg} << 4) + 8);
                res_next[32:17] = 16'(({3'd0, need_reg} << 4) - 16'd8);
            end
        end
        else if (op_reg == OP_QUERY && hit_reg)
        begin
            res_next[32:17] = 16'(({4'd0, hit_size_reg} << 4) - 8);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= opcode_t'(in_op);
            req_zero_reg <= (in_req == 16'd0);
            addr_ok_reg  <= (in_off[3:0] == 4'd8) &&
                            (CMP_W'(in_off[15:4]) < CMP_W'(gran_reg));
            need_reg     <= need_sum[16:4];
            start_reg    <= in_off[15:4];
            found_reg    <= 1'b0;
            hit_reg      <= 1'b0;
        end
        if (cmd.walk_start)
        begin
            g_reg      <= GW'(FIRST_BLOCK);
            in_run_reg <= 1'b0;
        end
        if (cmd.step)
        begin
            g_reg <= g_add;
            if (op_reg == OP_ALLOC)
            begin
                if (fits && (!fit_mode_reg || !found_reg ||
                             CMP_W'(blk_size) < CMP_W'(best_size_reg)))
                begin
                    best_reg      <= g_reg[AW-1:0];
                    best_size_reg <= blk_size;
                    found_reg     <= 1'b1;
                end
            end
            else if (g_eq)
            begin
                hit_reg      <= 1'b1;
                hit_free_reg <= blk_free;
                hit_size_reg <= blk_size;
            end
        end
        if (cmd.merge_step)
        begin
            g_reg <= g_add;
            if (blk_free)
            begin
                if (in_run_reg)
                begin
                    acc_reg   <= acc_sum;
                    multi_reg <= 1'b1;
                end
                else
                begin
                    run_reg    <= g_reg[AW-1:0];
                    acc_reg    <= blk_size;
                    in_run_reg <= 1'b1;
                    multi_reg  <= 1'b0;
                end
            end
            else
            begin
                in_run_reg <= 1'b0;
            end
        end
        if (cmd.result_load)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    always_comb
    begin
        sts            = '0;
        sts.op         = op_reg;
        sts.req_zero   = req_zero_reg;
        sts.addr_ok    = addr_ok_reg;
        sts.walk_done  = end_c || stop_c;
        sts.merge_done = end_c;
        sts.found      = found_reg;
        sts.hit        = hit_reg;
        sts.hit_free   = hit_free_reg;
        sts.out_busy   = out_valid_reg && !m_tready;
    end

`ifndef SYNTHESIS
    a_cursor_in_arena: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step || cmd.merge_step) |-> (g_reg < gran_reg))
        else $error("walk cursor outside the arena");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");
    a_split_found: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.split_hi || cmd.split_lo) |-> found_reg)
        else $error("split without a chosen block");
`endif

endmodule

[src/free_list_block_allocator.sv]
// A transaction is accepted, decoded, then walks the block chain, reading and evaluating
// one block per step; allocate then writes the split (upper part, then lower part), and free
// marks the block free and makes a second full chain walk (merge pass). Throughput is one
// transaction at a time: a new one is taken only once the last result has been loaded. Both
// walks step through the single-read-port block store.
// Reset is asynchronous, active low; after reset the arena is rebuilt as one
// free block before the first transaction is taken.
module free_list_block_allocator #(
    parameter int ARENA_GRANULES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: opcode [1:0], request_bytes [17:2], payload_offset [33:18], zeros above
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    // m_tdata: status [0], result_offset [16:1], usable_bytes [32:17], zeros above
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);
    import flba_pkg::*;

    // The controller sequences each transaction; the datapath holds the block store,
    // the walk cursor and the result register.
    cmd_t cmd;
    sts_t sts;

    flba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    flba_dp #(
        .ARENA_GRANULES (ARENA_GRANULES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
